// ===== sv/vtc_pkg.sv =====
// Shared types, character codes and constants of the VT100 text console parser.
// Used by vtc_core, the top level and the testbench; depends on nothing else.
`default_nettype none

package vtc_pkg;

  localparam logic [1:0] KIND_GLYPH  = 2'd0;
  localparam logic [1:0] KIND_FILL   = 2'd1;
  localparam logic [1:0] KIND_CURSOR = 2'd2;

  localparam logic [1:0] REG_COLS = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;
  localparam logic [1:0] REG_BOOT = 2'd2;

  localparam logic [7:0] COLS_RESET = 8'd80;
  localparam logic [7:0] ROWS_RESET = 8'd25;
  localparam logic [7:0] COLS_MIN   = 8'd2;
  localparam logic [7:0] ROWS_MIN   = 8'd3;

  localparam logic [7:0] ATTR_NORMAL = 8'h0f;
  localparam logic [7:0] ATTR_BOOT   = 8'hf0;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_QUEST = 8'h3f;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_UP    = 8'h41;  // A
  localparam logic [7:0] CH_DOWN  = 8'h42;  // B
  localparam logic [7:0] CH_RIGHT = 8'h43;  // C
  localparam logic [7:0] CH_LEFT  = 8'h44;  // D
  localparam logic [7:0] CH_COLA  = 8'h47;  // G
  localparam logic [7:0] CH_HOME  = 8'h48;  // H
  localparam logic [7:0] CH_ERASE = 8'h4b;  // K
  localparam logic [7:0] CH_BTICK = 8'h60;  // backquote
  localparam logic [7:0] CH_RIGHT2 = 8'h61; // a
  localparam logic [7:0] CH_ROWA  = 8'h64;  // d
  localparam logic [7:0] CH_DOWN2 = 8'h65;  // e
  localparam logic [7:0] CH_HOME2 = 8'h66;  // f
  localparam logic [7:0] CH_SGR   = 8'h6d;  // m

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] fill_width;
    logic [1:0] fill_height;
    logic [7:0] glyph;
    logic [7:0] attr;
    logic       last_item;
  } emit_t;

  typedef struct packed {
    logic [7:0] cols;
    logic [7:0] rows;
    logic       boot;
    logic       upd;
  } cfg_t;

  function automatic logic [2:0] color_map(input logic [2:0] idx);
    logic [2:0] r;
    begin
      case (idx)
        3'd0: r = 3'd0;
        3'd1: r = 3'd4;
        3'd2: r = 3'd2;
        3'd3: r = 3'd6;
        3'd4: r = 3'd1;
        3'd5: r = 3'd5;
        3'd6: r = 3'd3;
        default: r = 3'd7;
      endcase
      return r;
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/vtc_alu.sv =====
// Shared cursor arithmetic: base plus or minus a distance, clamped into 0..lim-1.
// Pure logic; no package dependency.
`default_nettype none

module vtc_alu (
  input  wire logic [7:0]  base_i,
  input  wire logic [15:0] delta_i,
  input  wire logic        sub_i,
  input  wire logic [7:0]  lim_i,
  output logic [7:0]       res_o
);

  logic signed [17:0] sum;

  always_comb begin
    if (sub_i) begin
      sum = $signed({10'b0, base_i}) - $signed({2'b0, delta_i});
    end else begin
      sum = $signed({10'b0, base_i}) + $signed({2'b0, delta_i});
    end
    if (sum < 0) begin
      res_o = 8'd0;
    end else if (sum >= $signed({10'b0, lim_i})) begin
      res_o = lim_i - 8'd1;
    end else begin
      res_o = sum[7:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/vtc_args.sv =====
// Escape argument store with the saturating decimal accumulator.
// One write and one selectable read per cycle; the first two entries are also tapped.
`default_nettype none

module vtc_args #(
  parameter int MAX_ESC_ARGS = 8,
  localparam int IDXW = (MAX_ESC_ARGS > 1) ? $clog2(MAX_ESC_ARGS) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            wr_en_i,
  input  wire logic            wr_acc_i,
  input  wire logic [IDXW-1:0] wr_idx_i,
  input  wire logic [3:0]      digit_i,
  input  wire logic [IDXW-1:0] rd_idx_i,
  output logic [15:0]          rd_data_o,
  output logic [15:0]          arg0_o,
  output logic [15:0]          arg1_o
);

  logic [15:0] mem_q [MAX_ESC_ARGS];
  logic [19:0] acc;
  logic [15:0] wdata;

  assign rd_data_o = mem_q[rd_idx_i];
  assign arg0_o    = mem_q[0];

  generate
    if (MAX_ESC_ARGS > 1) begin : g_arg1
      assign arg1_o = mem_q[1];
    end else begin : g_noarg1
      assign arg1_o = 16'd0;
    end
  endgenerate

  // Multiply by ten as two shifts; the read port is pointed at the entry being written.
  always_comb begin
    acc = {1'b0, rd_data_o, 3'b0} + {3'b0, rd_data_o, 1'b0} + {16'b0, digit_i};
    if (!wr_acc_i) begin
      wdata = {12'b0, digit_i};
    end else if (acc > 20'd65535) begin
      wdata = 16'hffff;
    end else begin
      wdata = acc[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== sv/vtc_core.sv =====
// Parser sequencer: escape parsing, cursor, attribute and result generation.
// Depends on vtc_pkg, vtc_alu and vtc_args.
`default_nettype none

module vtc_core
  import vtc_pkg::*;
#(
  parameter int MAX_ESC_ARGS = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic       in_valid_i,
  input  wire logic [7:0] in_byte_i,
  output logic            in_ready_o,
  input  wire logic       emit_ok_i,
  output emit_t           emit_o
);

  localparam int IDXW = (MAX_ESC_ARGS > 1) ? $clog2(MAX_ESC_ARGS) : 1;
  localparam int CNTW = $clog2(MAX_ESC_ARGS + 1);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DECODE = 10'b0000000010,
    S_LS     = 10'b0000000100,
    S_LS2    = 10'b0000001000,
    S_GLYPH  = 10'b0000010000,
    S_MOVE_X = 10'b0000100000,
    S_MOVE_Y = 10'b0001000000,
    S_KFILL  = 10'b0010000000,
    S_SGR    = 10'b0100000000,
    S_CURSOR = 10'b1000000000
  } state_e;

  typedef enum logic [4:0] {
    P_NORMAL  = 5'b00001,
    P_ESCAPE  = 5'b00010,
    P_BRACKET = 5'b00100,
    P_NEWARG  = 5'b01000,
    P_ARG     = 5'b10000
  } pstate_e;

  state_e          state_q, state_d;
  pstate_e         pst_q, pst_d;
  logic [7:0]      cx_q, cx_d, cy_q, cy_d;
  logic [7:0]      attr_q, attr_d;
  logic            bright_q, bright_d;
  logic [IDXW-1:0] idx_q, idx_d;
  logic [IDXW-1:0] sgr_i_q, sgr_i_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [7:0]      byte_q, byte_d;
  logic [7:0]      glyph_q, glyph_d;
  logic            ginc_q, ginc_d;
  logic            lsg_q, lsg_d;
  logic [7:0]      cmd_q, cmd_d;

  logic            wr_en, wr_acc;
  logic [IDXW-1:0] wr_idx, rd_idx;
  logic [15:0]     rd_data, arg0, arg1;
  logic            is_digit;
  logic [3:0]      dval;
  logic            has0, has1, a0_nz, a1_nz;
  logic [15:0]     step_len, pos0, pos1;
  logic [7:0]      alu_base, alu_lim, alu_res;
  logic [15:0]     alu_delta;
  logic            alu_sub;
  logic [8:0]      tab_x;
  logic            run_cmd;
  logic [CNTW-1:0] run_cnt;
  logic [15:0]     sgr_v;
  logic [2:0]      sgr_col;
  logic [15:0]     sgr_off;

  vtc_args #(.MAX_ESC_ARGS(MAX_ESC_ARGS)) u_args (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_acc_i  (wr_acc),
    .wr_idx_i  (wr_idx),
    .digit_i   (dval),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data),
    .arg0_o    (arg0),
    .arg1_o    (arg1)
  );

  vtc_alu u_alu (
    .base_i  (alu_base),
    .delta_i (alu_delta),
    .sub_i   (alu_sub),
    .lim_i   (alu_lim),
    .res_o   (alu_res)
  );

  assign in_ready_o = (state_q == S_IDLE) && !cfg_i.upd;
  assign is_digit   = (byte_q >= CH_ZERO) && (byte_q <= CH_NINE);
  assign dval       = byte_q[3:0];
  assign rd_idx     = (state_q == S_SGR) ? sgr_i_q : idx_q;

  // Argument defaults: a missing or zero argument counts as one.
  assign has0     = (cnt_q != '0);
  assign has1     = (cnt_q > CNTW'(1));
  assign a0_nz    = has0 && (arg0 != 16'd0);
  assign a1_nz    = has1 && (arg1 != 16'd0);
  assign step_len = a0_nz ? arg0 : 16'd1;
  assign pos0     = a0_nz ? arg0 - 16'd1 : 16'd0;
  assign pos1     = a1_nz ? arg1 - 16'd1 : 16'd0;
  assign tab_x    = ({1'b0, cx_q} + 9'd8) & ~9'd7;

  // Foreground codes start at 30 and background codes at 40.
  assign sgr_v   = has0 ? rd_data : 16'd0;
  assign sgr_off = sgr_v - ((sgr_v >= 16'd40) ? 16'd40 : 16'd30);
  assign sgr_col = color_map(sgr_off[2:0]);

  always_comb begin
    alu_base  = cx_q;
    alu_delta = 16'd0;
    alu_sub   = 1'b0;
    alu_lim   = cfg_i.cols;
    if (state_q == S_MOVE_Y) begin
      alu_base = cy_q;
      alu_lim  = cfg_i.rows;
      case (cmd_q)
        CH_HOME, CH_HOME2, CH_ROWA: begin
          alu_base  = 8'd0;
          alu_delta = pos0;
        end
        CH_UP: begin
          alu_delta = step_len;
          alu_sub   = 1'b1;
        end
        CH_DOWN, CH_DOWN2: begin
          alu_delta = step_len;
        end
        default: begin
          alu_delta = 16'd0;
        end
      endcase
    end else begin
      case (cmd_q)
        CH_HOME, CH_HOME2: begin
          alu_base  = 8'd0;
          alu_delta = pos1;
        end
        CH_COLA, CH_BTICK: begin
          alu_base  = 8'd0;
          alu_delta = pos0;
        end
        CH_RIGHT, CH_RIGHT2: begin
          alu_delta = step_len;
        end
        CH_LEFT: begin
          alu_delta = step_len;
          alu_sub   = 1'b1;
        end
        default: begin
          alu_delta = 16'd0;
        end
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    pst_d    = pst_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    attr_d   = attr_q;
    bright_d = bright_q;
    idx_d    = idx_q;
    sgr_i_d  = sgr_i_q;
    cnt_d    = cnt_q;
    byte_d   = byte_q;
    glyph_d  = glyph_q;
    ginc_d   = ginc_q;
    lsg_d    = lsg_q;
    cmd_d    = cmd_q;
    wr_en    = 1'b0;
    wr_acc   = 1'b0;
    wr_idx   = idx_q;
    run_cmd  = 1'b0;
    run_cnt  = '0;
    emit_o   = '0;

    case (state_q)
      S_IDLE: begin
        if (cfg_i.upd) begin
          if (cx_q > cfg_i.cols - 8'd1) cx_d = cfg_i.cols - 8'd1;
          if (cy_q > cfg_i.rows - 8'd1) cy_d = cfg_i.rows - 8'd1;
        end else if (in_valid_i) begin
          byte_d  = in_byte_i;
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        state_d = S_CURSOR;
        case (pst_q)
          P_NORMAL: begin
            if (byte_q == CH_LF) begin
              lsg_d   = 1'b0;
              state_d = S_LS;
            end else if (byte_q == CH_BS) begin
              if (cx_q != 8'd0) begin
                cx_d    = cx_q - 8'd1;
                glyph_d = CH_SPACE;
                ginc_d  = 1'b0;
                state_d = S_GLYPH;
              end
            end else if (byte_q == CH_TAB) begin
              if (tab_x >= {1'b0, cfg_i.cols}) begin
                lsg_d   = 1'b0;
                state_d = S_LS;
              end else begin
                cx_d = tab_x[7:0];
              end
            end else if (byte_q == CH_CR || byte_q == CH_NUL || byte_q == CH_BEL) begin
              state_d = S_CURSOR;
            end else if (byte_q == CH_ESC) begin
              idx_d = '0;
              pst_d = P_ESCAPE;
            end else begin
              glyph_d = byte_q;
              ginc_d  = 1'b1;
              // A glyph never lands in the last column: wrap first.
              if ({1'b0, cx_q} + 9'd1 >= {1'b0, cfg_i.cols}) begin
                lsg_d   = 1'b1;
                state_d = S_LS;
              end else begin
                state_d = S_GLYPH;
              end
            end
          end
          P_ESCAPE: begin
            pst_d = (byte_q == CH_LBRK) ? P_BRACKET : P_NORMAL;
          end
          P_BRACKET: begin
            if (is_digit) begin
              idx_d  = '0;
              wr_en  = 1'b1;
              wr_idx = '0;
              pst_d  = P_ARG;
            end else if (byte_q != CH_QUEST) begin
              run_cmd = 1'b1;
              run_cnt = '0;
            end
          end
          P_NEWARG: begin
            if (is_digit) begin
              if (idx_q == IDXW'(MAX_ESC_ARGS - 1)) begin
                pst_d = P_NORMAL;
              end else begin
                idx_d  = idx_q + IDXW'(1);
                wr_en  = 1'b1;
                wr_idx = idx_q + IDXW'(1);
                pst_d  = P_ARG;
              end
            end else begin
              run_cmd = 1'b1;
              run_cnt = CNTW'(idx_q) + CNTW'(1);
            end
          end
          default: begin
            if (is_digit) begin
              wr_en  = 1'b1;
              wr_acc = 1'b1;
            end else if (byte_q == CH_SEMI) begin
              pst_d = P_NEWARG;
            end else begin
              run_cmd = 1'b1;
              run_cnt = CNTW'(idx_q) + CNTW'(1);
            end
          end
        endcase
        if (run_cmd) begin
          pst_d   = P_NORMAL;
          cnt_d   = run_cnt;
          cmd_d   = byte_q;
          sgr_i_d = '0;
          case (byte_q)
            CH_HOME, CH_HOME2, CH_UP, CH_DOWN, CH_DOWN2, CH_RIGHT, CH_RIGHT2,
            CH_LEFT, CH_COLA, CH_BTICK, CH_ROWA: state_d = S_MOVE_X;
            CH_ERASE: state_d = S_KFILL;
            CH_SGR:   state_d = S_SGR;
            default:  state_d = S_CURSOR;
          endcase
        end
      end

      S_LS: begin
        if (cy_q >= cfg_i.rows - 8'd1) begin
          emit_o.valid       = 1'b1;
          emit_o.kind        = KIND_FILL;
          emit_o.fill_width  = cfg_i.cols;
          emit_o.fill_height = 2'd2;
          emit_o.glyph       = CH_SPACE;
          emit_o.attr        = attr_q;
          if (emit_ok_i) begin
            cy_d    = 8'd0;
            state_d = S_LS2;
          end
        end else begin
          cy_d    = cy_q + 8'd1;
          state_d = S_LS2;
        end
      end

      S_LS2: begin
        // Clear the row two below the new cursor row when it exists.
        if ({1'b0, cy_q} + 9'd2 < {1'b0, cfg_i.rows}) begin
          emit_o.valid       = 1'b1;
          emit_o.kind        = KIND_FILL;
          emit_o.pos_y       = cy_q + 8'd2;
          emit_o.fill_width  = cfg_i.cols;
          emit_o.fill_height = 2'd1;
          emit_o.glyph       = CH_SPACE;
          emit_o.attr        = attr_q;
        end
        if (!emit_o.valid || emit_ok_i) begin
          cx_d    = 8'd0;
          state_d = lsg_q ? S_GLYPH : S_CURSOR;
        end
      end

      S_GLYPH: begin
        emit_o.valid = 1'b1;
        emit_o.kind  = KIND_GLYPH;
        emit_o.pos_x = cx_q;
        emit_o.pos_y = cy_q;
        emit_o.glyph = glyph_q;
        emit_o.attr  = attr_q;
        if (emit_ok_i) begin
          if (ginc_q) cx_d = cx_q + 8'd1;
          state_d = S_CURSOR;
        end
      end

      S_MOVE_X: begin
        cx_d    = alu_res;
        state_d = S_MOVE_Y;
      end

      S_MOVE_Y: begin
        cy_d    = alu_res;
        state_d = S_CURSOR;
      end

      S_KFILL: begin
        emit_o.kind        = KIND_FILL;
        emit_o.pos_y       = cy_q;
        emit_o.fill_height = 2'd1;
        emit_o.glyph       = CH_SPACE;
        emit_o.attr        = attr_q;
        if (!a0_nz) begin
          emit_o.valid      = 1'b1;
          emit_o.pos_x      = cx_q;
          emit_o.fill_width = cfg_i.cols - cx_q;
        end else if (arg0 == 16'd1) begin
          emit_o.valid      = 1'b1;
          emit_o.fill_width = cx_q + 8'd1;
        end else if (arg0 == 16'd2) begin
          emit_o.valid      = 1'b1;
          emit_o.fill_width = cfg_i.cols;
        end
        if (!emit_o.valid || emit_ok_i) begin
          state_d = S_CURSOR;
        end
      end

      S_SGR: begin
        case (sgr_v)
          16'd0: begin
            attr_d   = cfg_i.boot ? ATTR_BOOT : ATTR_NORMAL;
            bright_d = 1'b1;
          end
          16'd1: begin
            bright_d  = 1'b1;
            attr_d[3] = 1'b1;
          end
          16'd2: begin
            bright_d  = 1'b0;
            attr_d[3] = 1'b0;
          end
          16'd5: begin
            attr_d[7] = 1'b1;
          end
          16'd7: begin
            attr_d = {attr_q[3:0], bright_q, attr_q[6:4]};
          end
          default: begin
            if (sgr_v >= 16'd30 && sgr_v <= 16'd37) begin
              attr_d = {attr_q[7:4], bright_q, sgr_col};
            end else if (sgr_v >= 16'd40 && sgr_v <= 16'd47) begin
              attr_d = {attr_q[7], sgr_col, attr_q[3:0]};
            end
          end
        endcase
        if (!has0 || (CNTW'(sgr_i_q) + CNTW'(1) >= cnt_q)) begin
          state_d = S_CURSOR;
        end else begin
          sgr_i_d = sgr_i_q + IDXW'(1);
        end
      end

      S_CURSOR: begin
        emit_o.valid     = 1'b1;
        emit_o.kind      = KIND_CURSOR;
        emit_o.pos_x     = cx_q;
        emit_o.pos_y     = cy_q;
        emit_o.last_item = 1'b1;
        if (emit_ok_i) state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pst_q    <= P_NORMAL;
      cx_q     <= 8'd0;
      cy_q     <= 8'd0;
      attr_q   <= ATTR_NORMAL;
      bright_q <= 1'b0;
      idx_q    <= '0;
      sgr_i_q  <= '0;
      cnt_q    <= '0;
      ginc_q   <= 1'b0;
      lsg_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      pst_q    <= pst_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      attr_q   <= attr_d;
      bright_q <= bright_d;
      idx_q    <= idx_d;
      sgr_i_q  <= sgr_i_d;
      cnt_q    <= cnt_d;
      ginc_q   <= ginc_d;
      lsg_q    <= lsg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    glyph_q <= glyph_d;
    cmd_q   <= cmd_d;
  end

endmodule

`default_nettype wire

// ===== sv/vt100_text_console_parser_top.sv =====
// A byte is accepted in an idle cycle, then runs DECODE and CURSOR if it only changes state,
// with GLYPH or KFILL between for a glyph, backspace or erase, MOVE_X, MOVE_Y for a motion, LS,
// LS2 for a line step, LS, LS2, GLYPH for a wrapping glyph, SGR walking each stored argument for an
// SGR. The next byte waits for idle; results are registered, one per cycle unless stalled.
// Reset (rst_ni low, asynchronous) homes the cursor, sets attribute 0x0f and restores
// the register defaults 80 columns, 25 rows and normal colors.
`default_nettype none

module vt100_text_console_parser_top
  import vtc_pkg::*;
#(
  parameter int MAX_ESC_ARGS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       pos_x_o,
  output logic [7:0]       pos_y_o,
  output logic [7:0]       fill_width_o,
  output logic [1:0]       fill_height_o,
  output logic [7:0]       glyph_o,
  output logic [7:0]       attr_o,
  output logic             last_item_o
);

  logic [7:0] cols_q, cols_d, rows_q, rows_d;
  logic       boot_q, boot_d;
  logic       upd_q, upd_d;
  logic       wr;
  logic [1:0] reg_idx;
  cfg_t       cfg;
  emit_t      emit;
  emit_t      out_q;
  logic       out_valid_q, out_valid_d;
  logic       emit_ok;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    case (reg_idx)
      REG_COLS: prdata = {24'd0, cols_q};
      REG_ROWS: prdata = {24'd0, rows_q};
      REG_BOOT: prdata = {31'd0, boot_q};
      default:  prdata = 32'd0;
    endcase
  end

  always_comb begin
    cols_d = cols_q;
    rows_d = rows_q;
    boot_d = boot_q;
    upd_d  = 1'b0;
    if (wr) begin
      case (reg_idx)
        REG_COLS: begin
          cols_d = (pwdata[7:0] < COLS_MIN) ? COLS_MIN : pwdata[7:0];
          upd_d  = 1'b1;
        end
        REG_ROWS: begin
          rows_d = (pwdata[7:0] < ROWS_MIN) ? ROWS_MIN : pwdata[7:0];
          upd_d  = 1'b1;
        end
        REG_BOOT: boot_d = pwdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = '{cols: cols_q, rows: rows_q, boot: boot_q, upd: upd_q};

  // The output register frees up in the same cycle its transaction completes.
  assign emit_ok     = !out_valid_q || out_ready_i;
  assign out_valid_d = (emit.valid && emit_ok) ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  vtc_core #(.MAX_ESC_ARGS(MAX_ESC_ARGS)) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .in_ready_o (in_ready_o),
    .emit_ok_i  (emit_ok),
    .emit_o     (emit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q      <= COLS_RESET;
      rows_q      <= ROWS_RESET;
      boot_q      <= 1'b0;
      upd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cols_q      <= cols_d;
      rows_q      <= rows_d;
      boot_q      <= boot_d;
      upd_q       <= upd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid && emit_ok) begin
      out_q <= emit;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_q.kind;
  assign pos_x_o       = out_q.pos_x;
  assign pos_y_o       = out_q.pos_y;
  assign fill_width_o  = out_q.fill_width;
  assign fill_height_o = out_q.fill_height;
  assign glyph_o       = out_q.glyph;
  assign attr_o        = out_q.attr;
  assign last_item_o   = out_q.last_item;

endmodule

`default_nettype wire

// ===== test/vt100_text_console_parser_top_tb.sv =====
// Self-checking testbench of the VT100 text console parser top level.
// Depends on vtc_pkg and vt100_text_console_parser_top; a built-in predictor
// renders every accepted byte and a scoreboard checks each result in order.
`timescale 1ns / 1ps

module vt100_text_console_parser_top_tb;
  import vtc_pkg::*;

  localparam int ESC_ARGS = 8;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum int {PS_NORMAL, PS_ESC, PS_BRACKET, PS_NEWARG, PS_ARG} parse_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] fill_width;
    logic [1:0] fill_height;
    logic [7:0] glyph;
    logic [7:0] attr;
    logic       last_item;
  } draw_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  pos_x_o, pos_y_o, fill_width_o, glyph_o, attr_o;
  logic [1:0]  fill_height_o;
  logic        last_item_o;

  vt100_text_console_parser_top #(.MAX_ESC_ARGS(ESC_ARGS)) dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state.
  int       scr_cols, scr_rows, boot_sel;
  parse_e   pstate;
  int       cur_x, cur_y, arg_idx;
  logic [7:0] cur_attr;
  logic     bright;
  int       args [ESC_ARGS];
  int       step_results;
  logic [2:0] ansi_to_vga [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

  draw_t    draw_q [$];
  int       mismatches = 0;
  bit       idle_off = 1'b0;
  int       quiet_cycles = 0;

  task automatic push_draw(int kind, int x, int y, int w, int h, int g, int a, bit last);
    draw_t d;
    if (step_results < 4) begin
      d.kind = kind[1:0]; d.pos_x = x[7:0]; d.pos_y = y[7:0];
      d.fill_width = w[7:0]; d.fill_height = h[1:0];
      d.glyph = g[7:0]; d.attr = a[7:0]; d.last_item = last;
      draw_q.push_back(d);
      step_results++;
    end
  endtask

  task automatic push_fill(int x, int y, int w, int h);
    push_draw(KIND_FILL, x, y, w, h, CH_SPACE, cur_attr, 1'b0);
  endtask

  function automatic int clip(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic place_cursor(int x, int y);
    cur_x = clip(x, 0, scr_cols - 1);
    cur_y = clip(y, 0, scr_rows - 1);
  endtask

  task automatic advance_row();
    if (cur_y >= scr_rows - 1) begin
      cur_y = 0;
      push_fill(0, 0, scr_cols, 2);
    end else begin
      cur_y++;
    end
    if (cur_y + 2 < scr_rows) push_fill(0, cur_y + 2, scr_cols, 1);
    cur_x = 0;
  endtask

  task automatic apply_attrs(int count);
    logic [7:0] a;
    int v;
    if (count == 0) begin
      count = 1;
      args[0] = 0;
    end
    for (int i = 0; i < count && i < ESC_ARGS; i++) begin
      v = args[i];
      a = cur_attr;
      if (v == 0) begin
        a = boot_sel ? ATTR_BOOT : ATTR_NORMAL;
        bright = 1'b1;
      end else if (v == 1) begin
        bright = 1'b1;
        a[3] = 1'b1;
      end else if (v == 2) begin
        bright = 1'b0;
        a[3] = 1'b0;
      end else if (v == 5) begin
        a[7] = 1'b1;
      end else if (v == 7) begin
        a = {a[3:0], 1'b0, a[6:4]};
        if (bright) a[3] = 1'b1;
      end else if (v >= 30 && v <= 37) begin
        a[3:0] = {bright, ansi_to_vga[v - 30]};
      end else if (v >= 40 && v <= 47) begin
        a[6:4] = ansi_to_vga[v - 40];
      end
      cur_attr = a;
    end
  endtask

  task automatic run_final(logic [7:0] c, int count);
    int a0, a1, d, row, col;
    a0 = count > 0 ? args[0] : -1;
    a1 = count > 1 ? args[1] : -1;
    d = a0 >= 0 ? a0 : 1;
    case (c)
      CH_HOME, CH_HOME2: begin
        row = a0 >= 0 ? a0 : 1;
        col = a1 >= 0 ? a1 : 1;
        if (row > 0) row--;
        if (col > 0) col--;
        place_cursor(col, row);
      end
      CH_UP: place_cursor(cur_x, cur_y - (d == 0 ? 1 : d));
      CH_DOWN, CH_DOWN2: place_cursor(cur_x, cur_y + (d == 0 ? 1 : d));
      CH_LEFT: place_cursor(cur_x - (d == 0 ? 1 : d), cur_y);
      CH_RIGHT, CH_RIGHT2: place_cursor(cur_x + (d == 0 ? 1 : d), cur_y);
      CH_COLA, CH_BTICK: place_cursor(d > 0 ? d - 1 : d, cur_y);
      CH_ROWA: place_cursor(cur_x, d > 0 ? d - 1 : d);
      CH_ERASE: begin
        if (a0 <= 0) push_fill(cur_x, cur_y, scr_cols - cur_x, 1);
        else if (a0 == 1) push_fill(0, cur_y, cur_x + 1, 1);
        else if (a0 == 2) push_fill(0, cur_y, scr_cols, 1);
      end
      CH_SGR: apply_attrs(count);
      default: ;
    endcase
  endtask

  // Renders one accepted byte into the queue of expected draw results.
  task automatic render_byte(logic [7:0] c);
    bit digit;
    int v;
    step_results = 0;
    digit = c >= CH_ZERO && c <= CH_NINE;
    case (pstate)
      PS_NORMAL: begin
        if (c == CH_LF) begin
          advance_row();
        end else if (c == CH_BS) begin
          if (cur_x > 0) begin
            cur_x--;
            push_draw(KIND_GLYPH, cur_x, cur_y, 0, 0, CH_SPACE, cur_attr, 1'b0);
          end
        end else if (c == CH_TAB) begin
          cur_x = (cur_x + 8) & ~7;
          if (cur_x >= scr_cols) advance_row();
        end else if (c == CH_CR || c == CH_NUL || c == CH_BEL) begin
        end else if (c == CH_ESC) begin
          arg_idx = 0;
          pstate = PS_ESC;
        end else begin
          cur_x++;
          if (cur_x >= scr_cols) begin
            advance_row();
            cur_x++;
          end
          push_draw(KIND_GLYPH, cur_x - 1, cur_y, 0, 0, c, cur_attr, 1'b0);
        end
      end
      PS_ESC: begin
        if (c == CH_LBRK) pstate = PS_BRACKET;
        else begin
          args[0] = 0;
          pstate = PS_NORMAL;
        end
      end
      PS_BRACKET: begin
        if (digit) begin
          arg_idx = 0;
          args[0] = c - CH_ZERO;
          pstate = PS_ARG;
        end else if (c != CH_QUEST) begin
          run_final(c, 0);
          pstate = PS_NORMAL;
        end
      end
      PS_NEWARG: begin
        if (digit) begin
          arg_idx++;
          if (arg_idx >= ESC_ARGS) begin
            arg_idx = ESC_ARGS;
            pstate = PS_NORMAL;
          end else begin
            args[arg_idx] = c - CH_ZERO;
            pstate = PS_ARG;
          end
        end else begin
          run_final(c, arg_idx + 1);
          pstate = PS_NORMAL;
        end
      end
      default: begin
        if (digit) begin
          if (arg_idx < ESC_ARGS) begin
            v = args[arg_idx] * 10 + (c - CH_ZERO);
            args[arg_idx] = v > 65535 ? 65535 : v;
          end
        end else if (c == CH_SEMI) begin
          pstate = PS_NEWARG;
        end else begin
          run_final(c, arg_idx + 1);
          pstate = PS_NORMAL;
        end
      end
    endcase
    push_draw(KIND_CURSOR, cur_x, cur_y, 0, 0, 0, 0, 1'b1);
  endtask

  // Sends one byte; valid stays high into the next call unless a gap is taken.
  task automatic send_byte(logic [7:0] b);
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    render_byte(b);
    @(negedge clk_i);
    if (!idle_off && $urandom_range(3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  endtask

  task automatic send_seq(logic [7:0] s [$]);
    foreach (s[i]) send_byte(s[i]);
  endtask

  // Waits until the block has delivered everything and settled.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (draw_q.size() != 0) @(negedge clk_i);
    repeat (ESC_ARGS + 8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    int v;
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    v = value[7:0];
    if (idx == REG_COLS) begin
      scr_cols = v < COLS_MIN ? COLS_MIN : v;
      place_cursor(cur_x, cur_y);
    end else if (idx == REG_ROWS) begin
      scr_rows = v < ROWS_MIN ? ROWS_MIN : v;
      place_cursor(cur_x, cur_y);
    end else if (idx == REG_BOOT) begin
      boot_sel = value[0];
    end
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_screen(int cols, int rows, bit boot);
    drain();
    write_reg(REG_COLS, {8'($urandom_range(255, 0)), 16'h0, cols[7:0]});
    write_reg(REG_ROWS, {8'($urandom_range(255, 0)), 16'h0, rows[7:0]});
    write_reg(REG_BOOT, {8'($urandom_range(255, 0)), 23'h0, boot});
  endtask

  task automatic push_number(ref logic [7:0] s [$], input int n);
    string t;
    t = $sformatf("%0d", n);
    for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
  endtask

  task automatic test_directed();
    logic [7:0] s [$];
    set_screen(4, 3, 1'b0);
    s = '{8'hff, 8'h41, 8'h7e, 8'h42, 8'h43, CH_LF, CH_TAB, CH_TAB, CH_BS, CH_CR,
          CH_NUL, CH_BEL, CH_ESC, 8'h78, CH_ESC, CH_LBRK, CH_QUEST, CH_HOME};
    send_seq(s);
    for (int i = 0; i < 6; i++) send_byte(CH_BS);
    s = {CH_ESC, CH_LBRK};
    push_number(s, 99999);
    s.push_back(CH_HOME);
    send_seq(s);
    s = {CH_ESC, CH_LBRK};
    for (int i = 0; i < ESC_ARGS; i++) begin
      s.push_back(8'h31); s.push_back(CH_SEMI);
    end
    s.push_back(8'h32); s.push_back(CH_SGR);
    send_seq(s);
    s = '{CH_ESC, CH_LBRK, 8'h30, CH_SEMI, 8'h31, CH_SEMI, 8'h35, CH_SEMI, 8'h37,
          CH_SEMI, 8'h33, 8'h31, CH_SEMI, 8'h34, 8'h32, CH_SEMI, 8'h32, CH_SGR,
          CH_ESC, CH_LBRK, 8'h31, CH_ERASE, CH_ESC, CH_LBRK, 8'h7a, 8'h5a};
    send_seq(s);
    set_screen(255, 255, 1'b1);
    s = '{CH_ESC, CH_LBRK, 8'h32, 8'h35, 8'h35, CH_SEMI, 8'h32, 8'h35, 8'h35, CH_HOME2,
          8'h21, CH_ESC, CH_LBRK, CH_SGR, CH_ESC, CH_LBRK, 8'h33, CH_ERASE,
          CH_LF, CH_TAB};
    send_seq(s);
  endtask

  // Mostly well-formed escape sequences with random content, text and control runs, plus noise.
  task automatic test_random(int n_bytes);
    logic [7:0] finals [14] = '{CH_HOME, CH_HOME2, CH_UP, CH_DOWN, CH_DOWN2, CH_LEFT,
                                CH_RIGHT, CH_RIGHT2, CH_COLA, CH_BTICK, CH_ROWA,
                                CH_ERASE, CH_SGR, 8'h5a};
    logic [7:0] s [$];
    int sent, nargs, pick;
    sent = 0;
    while (sent < n_bytes) begin
      s = {};
      pick = $urandom_range(99);
      if (pick < 55) begin
        s = {CH_ESC, CH_LBRK};
        if ($urandom_range(9) == 0) s.push_back(CH_QUEST);
        nargs = $urandom_range(ESC_ARGS + 1);
        for (int i = 0; i < nargs; i++) begin
          if (i > 0) s.push_back(CH_SEMI);
          case ($urandom_range(3))
            0: push_number(s, $urandom_range(9));
            1: push_number(s, $urandom_range(30, 47));
            2: push_number(s, $urandom_range(300));
            default: push_number(s, $urandom_range(99999));
          endcase
        end
        if ($urandom_range(9) == 0) s.push_back(8'($urandom_range(255)));
        else s.push_back(finals[$urandom_range(13)]);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(5))
            0: s.push_back(CH_LF);
            1: s.push_back(CH_BS);
            2: s.push_back(CH_TAB);
            default: s.push_back(8'($urandom_range(8'h21, 8'h7e)));
          endcase
        end
      end else begin
        s.push_back(8'($urandom_range(255)));
      end
      send_seq(s);
      sent += s.size();
    end
  endtask

  // Output side: random stall bursts unless idling is turned off.
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (idle_off) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(4) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    draw_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{kind_o, pos_x_o, pos_y_o, fill_width_o, fill_height_o, glyph_o, attr_o,
              last_item_o};
      if (draw_q.size() == 0) begin
        if (mismatches < 10) $display("unexpected result transaction: %p", got);
        mismatches++;
      end else begin
        want = draw_q.pop_front();
        if (got !== want) begin
          if (mismatches < 10) $display("result mismatch: expected %p, actual %p", want, got);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    scr_cols = COLS_RESET; scr_rows = ROWS_RESET; boot_sel = 0;
    pstate = PS_NORMAL; cur_x = 0; cur_y = 0; cur_attr = ATTR_NORMAL;
    bright = 1'b0; arg_idx = 0;
    foreach (args[i]) args[i] = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_random(15);
    test_directed();
    set_screen(2, 3, 1'b1);
    test_random(35);
    set_screen(0, 1, 1'b0);
    test_random(15);
    set_screen($urandom_range(2, 20), $urandom_range(3, 12), 1'($urandom_range(1)));
    test_random(35);
    set_screen(255, 255, 1'b0);
    test_random(10);
    set_screen($urandom_range(5, 40), $urandom_range(3, 30), 1'b1);
    idle_off = 1'b1;
    test_random(25);
    drain();
    repeat (20) @(negedge clk_i);
    if (mismatches == 0 && draw_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
